FILE: sv/rlp_pkg.sv
// ---------------------------------------------------------------------------
// Relocating loader patch package
// Shared beat types, operation and status codes, and the sequencer states.
// ---------------------------------------------------------------------------
package rlp_pkg;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_MODIFY = 2'd1;
  localparam logic [1:0] MODE_JUMP   = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BEYOND     = 2'd1;
  localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

  // One memory word is a loaded mark on top of the stored byte.
  localparam int unsigned RamWidth = 9;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  nibble_count;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] relocated_address;
    logic [7:0]  read_data;
  } out_beat_t;

  typedef logic [15:0] cfg_beat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RD,
    S_CALC,
    S_WR,
    S_RESP
  } seq_state_e;

endpackage

FILE: sv/rlp_chan_if.sv
// ---------------------------------------------------------------------------
// Relocating loader patch channel
// Valid/ready channel carrying one payload beat of a chosen type.
// ---------------------------------------------------------------------------
interface rlp_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: sv/rlp_ram.sv
// ---------------------------------------------------------------------------
// Relocating loader patch RAM
// Generic single-port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
module rlp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old contents on a same-cycle write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rlp_seq.sv
// ---------------------------------------------------------------------------
// Relocating loader patch sequencer
// Runs one item at a time against the memory: clearing pass after reset,
// range check, byte reads, field add and byte write-back.
// ---------------------------------------------------------------------------
module rlp_seq
  import rlp_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 4096,
  localparam int unsigned AddrW = $clog2(MEM_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_beat_t            in_beat_i,
  input  logic [15:0]         offset_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output out_beat_t           res_o,
  output logic                ram_we_o,
  output logic [AddrW-1:0]    ram_addr_o,
  output logic [RamWidth-1:0] ram_wdata_o,
  input  logic [RamWidth-1:0] ram_rdata_i
);

  localparam logic [16:0]      DepthL   = 17'(MEM_DEPTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MEM_DEPTH - 1);

  seq_state_e state_q, state_d;

  logic [AddrW-1:0] clr_q;
  logic [1:0]       mode_q;
  logic [15:0]      addr_q;
  logic [15:0]      reloc_q;
  logic [7:0]       byte_q;
  logic [2:0]       nib_q;
  logic [1:0]       nbytes_q;
  logic [1:0]       rd_cnt_q;
  logic [1:0]       wr_cnt_q;
  logic [23:0]      val_q;
  logic [23:0]      new_q;
  logic             mk_q;
  logic [1:0]       status_q;
  logic [7:0]       rdata_q;

  logic [2:0]  nib_in;
  logic [16:0] start;
  logic        oob;
  logic [16:0] rd_addr;
  logic [16:0] wr_addr;
  logic [23:0] mask;
  logic [23:0] sum;
  logic [23:0] patched;
  logic [1:0]  wr_shift;
  logic [7:0]  wr_byte;
  logic        accept;

  // Clamp the nibble count into one to six.
  always_comb begin
    unique case (in_beat_i.nibble_count)
      3'd0:    nib_in = 3'd1;
      3'd7:    nib_in = 3'd6;
      default: nib_in = in_beat_i.nibble_count;
    endcase
  end

  // Field mask for the clamped count.
  always_comb begin
    unique case (nib_q)
      3'd1:    mask = 24'h00000F;
      3'd2:    mask = 24'h0000FF;
      3'd3:    mask = 24'h000FFF;
      3'd4:    mask = 24'h00FFFF;
      3'd5:    mask = 24'h0FFFFF;
      default: mask = 24'hFFFFFF;
    endcase
  end

  // Address and range logic. A read item uses its address as given.
  assign start   = (mode_q == MODE_READ) ? {1'b0, addr_q} : {1'b0, reloc_q};
  assign oob     = (start + {15'd0, nbytes_q}) > DepthL;
  assign rd_addr = start + {15'd0, rd_cnt_q};
  assign wr_addr = start + {15'd0, wr_cnt_q};

  // Field add; bits above the field keep their old value.
  assign sum     = val_q + {8'd0, offset_i};
  assign patched = (val_q & ~mask) | (sum & mask);

  // Most significant byte of the field goes out first.
  assign wr_shift = nbytes_q - 2'd1 - wr_cnt_q;
  always_comb begin
    unique case (wr_shift)
      2'd0:    wr_byte = new_q[7:0];
      2'd1:    wr_byte = new_q[15:8];
      default: wr_byte = new_q[23:16];
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == LastAddr) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        if ((mode_q == MODE_TEXT) || (mode_q == MODE_JUMP) || oob) begin
          state_d = S_RESP;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD:    if (rd_cnt_q == nbytes_q) state_d = S_CALC;
      S_CALC: begin
        if (!mk_q || (mode_q == MODE_READ)) begin
          state_d = S_RESP;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR:    if (wr_cnt_q == nbytes_q - 2'd1) state_d = S_RESP;
      S_RESP:  if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake and memory port outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = rd_addr[AddrW-1:0];
    ram_wdata_o = '0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we_o   = 1'b1;
        ram_addr_o = clr_q;
      end
      S_IDLE:  in_ready_o = 1'b1;
      S_EXEC: begin
        if (mode_q == MODE_TEXT) begin
          ram_we_o    = !oob;
          ram_addr_o  = reloc_q[AddrW-1:0];
          ram_wdata_o = {1'b1, byte_q};
        end
      end
      S_WR: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = wr_addr[AddrW-1:0];
        ram_wdata_o = {1'b1, wr_byte};
      end
      S_RESP:  res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Control registers. The read counter is cleared while idle, so the
  // first byte of the next item is addressed at its start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      rd_cnt_q <= '0;
      wr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (state_q == S_IDLE) begin
        rd_cnt_q <= '0;
      end else if (state_q == S_EXEC) begin
        rd_cnt_q <= 2'd1;
      end else if ((state_q == S_RD) && (rd_cnt_q != nbytes_q)) begin
        rd_cnt_q <= rd_cnt_q + 2'd1;
      end
      if (state_q == S_CALC) begin
        wr_cnt_q <= '0;
      end else if (state_q == S_WR) begin
        wr_cnt_q <= wr_cnt_q + 2'd1;
      end
    end
  end

  // Item payload and working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= in_beat_i.mode;
      addr_q   <= in_beat_i.address;
      reloc_q  <= in_beat_i.address + offset_i;
      byte_q   <= in_beat_i.data_byte;
      nib_q    <= nib_in;
      nbytes_q <= (in_beat_i.mode == MODE_MODIFY) ? 2'((nib_in + 3'd1) >> 1) : 2'd1;
      status_q <= STATUS_OK;
      rdata_q  <= '0;
    end
    if (state_q == S_EXEC) begin
      val_q <= '0;
      mk_q  <= 1'b1;
      if (oob && (mode_q != MODE_JUMP)) begin
        status_q <= STATUS_BEYOND;
      end
    end
    // Each read beat shifts in one byte and its loaded mark.
    if (state_q == S_RD) begin
      val_q <= {val_q[15:0], ram_rdata_i[7:0]};
      mk_q  <= mk_q & ram_rdata_i[RamWidth-1];
    end
    if (state_q == S_CALC) begin
      new_q <= patched;
      if (!mk_q) begin
        status_q <= STATUS_NOT_LOADED;
      end else if (mode_q == MODE_READ) begin
        rdata_q <= val_q[7:0];
      end
    end
  end

  // Result beat.
  assign res_o.status            = status_q;
  assign res_o.relocated_address = (mode_q == MODE_READ) ? addr_q : reloc_q;
  assign res_o.read_data         = rdata_q;

  // All reads of an item are in before any gathered value is used.
  a_calc_after_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> (rd_cnt_q == nbytes_q))
    else $error("field used before all bytes were read");

  // Write-back only follows a check that found every byte loaded.
  a_wr_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> (mk_q && (status_q == STATUS_OK) && (mode_q == MODE_MODIFY)))
    else $error("write-back without a clean check");

  // No item is taken before the clearing pass ends.
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!in_ready_o && ram_we_o && (ram_wdata_o == '0)))
    else $error("clearing pass disturbed");

  // A delivered result leaves the sequencer ready for the next item.
  a_resp_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle");

endmodule

FILE: sv/relocating_loader_patch_top.sv
// ---------------------------------------------------------------------------
// Relocating loader patch top level
// Relocating loader: stores text bytes at relocated addresses, patches
// address fields by the relocation offset, and reads stored bytes back.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Payload                                      | Beat
//  --------+-----------+----------------------------------------------+------------------
//  in_ch   | sink      | mode, address, data_byte, nibble_count       | one item
//  out_ch  | source    | status, relocated_address, read_data         | one result/item
//  cfg_ch  | sink      | relocation_offset (16 bits)                  | one register write
//
//  After reset a clearing pass writes every memory word;
//  no item is taken during it, while configuration writes are taken always.
//  One item is worked at a time through the single memory port: store text, jump
//  and out-of-range items go through execute and respond, a read item also reads
//  and checks its byte, and a modify item reads each byte of its field, checks,
//  and writes each byte back only when all are loaded, before the next item is taken.
//  A finished result sits in the output register, so a stalled sink holds
//  the next item back only once it in turn reaches its result.
//
module relocating_loader_patch_top
  import rlp_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rlp_chan_if.sink   in_ch,
  rlp_chan_if.source out_ch,
  rlp_chan_if.sink   cfg_ch
);

  localparam int unsigned AddrW = $clog2(MEM_DEPTH);

  logic [15:0]         offset_q;
  logic                out_valid_q;
  out_beat_t           out_q;
  logic                res_valid;
  logic                res_ready;
  out_beat_t           res;
  logic                ram_we;
  logic [AddrW-1:0]    ram_addr;
  logic [RamWidth-1:0] ram_wdata;
  logic [RamWidth-1:0] ram_rdata;
  in_beat_t            in_beat;

  assign in_beat = in_ch.data;

  // Relocation offset register, always writable.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_ch.valid) begin
      offset_q <= 16'(cfg_ch.data);
    end
  end

  // Output register between the sequencer and the sink.
  assign res_ready = !out_valid_q || out_ch.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

  rlp_seq #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_beat_i   (in_beat),
    .offset_i    (offset_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  // Memory word: loaded mark and stored byte.
  rlp_ram #(
    .Width (RamWidth),
    .Depth (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: tb/sv/tb_relocating_loader_patch_top.sv
// ---------------------------------------------------------------------------
// Relocating loader patch testbench
// Drives load, patch, jump and read items through the input channel and
// checks every result beat against a scripted result or a behavioral model
// of the loader kept in this file. A short scripted sequence covers the
// memory edges, the error codes and the field length clamping. Random
// phases follow under several relocation offsets and backpressure patterns.
// ---------------------------------------------------------------------------
module tb_relocating_loader_patch_top;
  import rlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_DEPTH       = 4096;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned WATCHDOG_LIMIT  = 20000;
  localparam int unsigned NUM_ROWS        = 23;

  typedef enum logic {
    ROW_ITEM,
    ROW_CONFIG
  } row_kind_e;

  // One scripted step: an item beat, or an offset write carried in cfg_value.
  typedef struct {
    row_kind_e kind;
    cfg_beat_t cfg_value;
    in_beat_t  item;
    bit        typed;
    out_beat_t result;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rlp_chan_if #(.T(in_beat_t))  in_ch ();
  rlp_chan_if #(.T(out_beat_t)) out_ch ();
  rlp_chan_if #(.T(cfg_beat_t)) cfg_ch ();

  relocating_loader_patch_top #(
    .MEM_DEPTH(MEM_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Loader image as the testbench sees it.
  logic [7:0]  mem_image [MEM_DEPTH];
  bit          loaded_map [MEM_DEPTH];
  logic [15:0] reloc_offset = 16'h0000;

  out_beat_t   awaited_results [$];
  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // Scripted opening sequence, starting from the reset offset of zero.
  script_row_t script [NUM_ROWS] = '{
    '{ROW_ITEM, 16'h0, '{MODE_READ, 16'h0000, 8'h00, 3'd1}, 1'b1,
      '{STATUS_NOT_LOADED, 16'h0000, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_READ, 16'hFFFF, 8'h00, 3'd1}, 1'b1,
      '{STATUS_BEYOND, 16'hFFFF, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_JUMP, 16'hFFFF, 8'h00, 3'd1}, 1'b1,
      '{STATUS_OK, 16'hFFFF, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_TEXT, 16'h1000, 8'hAA, 3'd1}, 1'b1,
      '{STATUS_BEYOND, 16'h1000, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_TEXT, 16'h0FFF, 8'hFF, 3'd1}, 1'b1,
      '{STATUS_OK, 16'h0FFF, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_READ, 16'h0FFF, 8'h00, 3'd1}, 1'b1,
      '{STATUS_OK, 16'h0FFF, 8'hFF}},
    '{ROW_ITEM, 16'h0, '{MODE_MODIFY, 16'h0FFF, 8'h00, 3'd3}, 1'b1,
      '{STATUS_BEYOND, 16'h0FFF, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_MODIFY, 16'h0FFF, 8'h00, 3'd2}, 1'b0, '{2'd0, 16'h0, 8'h0}},
    '{ROW_ITEM, 16'h0, '{MODE_TEXT, 16'h0000, 8'h00, 3'd6}, 1'b1,
      '{STATUS_OK, 16'h0000, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_TEXT, 16'h0001, 8'hA5, 3'd6}, 1'b1,
      '{STATUS_OK, 16'h0001, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_TEXT, 16'h0002, 8'h5A, 3'd6}, 1'b1,
      '{STATUS_OK, 16'h0002, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_MODIFY, 16'h0001, 8'h00, 3'd6}, 1'b1,
      '{STATUS_NOT_LOADED, 16'h0001, 8'h00}},
    '{ROW_CONFIG, 16'hFFFF, '{MODE_JUMP, 16'h0, 8'h0, 3'd0}, 1'b0, '{2'd0, 16'h0, 8'h0}},
    '{ROW_ITEM, 16'h0, '{MODE_TEXT, 16'h0000, 8'h77, 3'd1}, 1'b1,
      '{STATUS_BEYOND, 16'hFFFF, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_TEXT, 16'h0004, 8'hC3, 3'd1}, 1'b1,
      '{STATUS_OK, 16'h0003, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_MODIFY, 16'h0001, 8'h00, 3'd5}, 1'b0, '{2'd0, 16'h0, 8'h0}},
    '{ROW_ITEM, 16'h0, '{MODE_MODIFY, 16'h0002, 8'h00, 3'd0}, 1'b0, '{2'd0, 16'h0, 8'h0}},
    '{ROW_ITEM, 16'h0, '{MODE_MODIFY, 16'h0002, 8'h00, 3'd7}, 1'b0, '{2'd0, 16'h0, 8'h0}},
    '{ROW_ITEM, 16'h0, '{MODE_MODIFY, 16'h0004, 8'h00, 3'd1}, 1'b0, '{2'd0, 16'h0, 8'h0}},
    '{ROW_ITEM, 16'h0, '{MODE_MODIFY, 16'h0000, 8'h00, 3'd4}, 1'b1,
      '{STATUS_BEYOND, 16'hFFFF, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_JUMP, 16'h0000, 8'h00, 3'd1}, 1'b1,
      '{STATUS_OK, 16'hFFFF, 8'h00}},
    '{ROW_ITEM, 16'h0, '{MODE_READ, 16'h0000, 8'h00, 3'd1}, 1'b0, '{2'd0, 16'h0, 8'h0}},
    '{ROW_ITEM, 16'h0, '{MODE_READ, 16'h0003, 8'h00, 3'd1}, 1'b0, '{2'd0, 16'h0, 8'h0}}
  };

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Status of a span of bytes: beyond the memory, partly unloaded, or usable.
  function automatic logic [1:0] span_status(input int unsigned start,
                                             input int unsigned count);
    logic [1:0] st;
    st = STATUS_OK;
    if (start + count > MEM_DEPTH) begin
      st = STATUS_BEYOND;
    end else begin
      for (int unsigned k = 0; k < count; k++) begin
        if (!loaded_map[start + k]) st = STATUS_NOT_LOADED;
      end
    end
    return st;
  endfunction

  // Apply one item to the loader image and return the result it must give.
  function automatic out_beat_t relocate_step(input in_beat_t item);
    out_beat_t   res;
    logic [15:0] reloc;
    int unsigned n;
    int unsigned idx;
    int unsigned value;
    int unsigned mask;
    reloc = item.address + reloc_offset;
    res = '{STATUS_OK, reloc, 8'h00};
    case (item.mode)
      MODE_TEXT: begin
        if (reloc >= MEM_DEPTH) begin
          res.status = STATUS_BEYOND;
        end else begin
          mem_image[reloc] = item.data_byte;
          loaded_map[reloc] = 1'b1;
        end
      end
      MODE_MODIFY: begin
        // Out-of-range counts are clamped to the nearest legal length.
        n = item.nibble_count;
        if (n < 1) n = 1;
        if (n > 6) n = 6;
        res.status = span_status(reloc, (n + 1) / 2);
        if (res.status == STATUS_OK) begin
          // Gather, most significant nibble first; an odd field starts low.
          idx = reloc;
          value = 0;
          if (n % 2 == 1) begin
            value = mem_image[idx] & 8'h0F;
            idx++;
          end
          for (int unsigned k = 0; k < n / 2; k++) begin
            value = (value << 8) | mem_image[idx];
            idx++;
          end
          mask = (1 << (4 * n)) - 1;
          value = (value + reloc_offset) & mask;
          // Scatter back, keeping the high nibble of an odd field's first byte.
          idx = reloc;
          if (n % 2 == 1) begin
            mem_image[idx] = {mem_image[idx][7:4], 4'(value >> (8 * (n / 2)))};
            idx++;
          end
          for (int unsigned k = n / 2; k > 0; k--) begin
            mem_image[idx] = 8'(value >> (8 * (k - 1)));
            idx++;
          end
        end
      end
      MODE_JUMP: begin
      end
      default: begin
        res.relocated_address = item.address;
        res.status = span_status(item.address, 1);
        if (res.status == STATUS_OK) res.read_data = mem_image[item.address];
      end
    endcase
    return res;
  endfunction

  // Random item, mostly aimed at a small hot window so that patches and reads
  // find loaded bytes; some land near the top edge, some are pure noise.
  function automatic in_beat_t random_item();
    in_beat_t    item;
    int unsigned roll;
    logic [15:0] target;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      item = in_beat_t'($urandom);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 80) target = 16'($urandom_range(0, 47));
      else if (roll < 92) target = 16'(MEM_DEPTH - 1 - $urandom_range(0, 7));
      else target = 16'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 35) item.mode = MODE_TEXT;
      else if (roll < 68) item.mode = MODE_MODIFY;
      else if (roll < 90) item.mode = MODE_READ;
      else item.mode = MODE_JUMP;
      item.address = (item.mode == MODE_READ) ? target : target - reloc_offset;
      item.data_byte = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) item.nibble_count = 3'($urandom_range(0, 7));
      else item.nibble_count = 3'($urandom_range(1, 6));
    end
    return item;
  endfunction

  // Present one item beat and return at the edge that accepts it.
  task automatic send_item(input in_beat_t item);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= item;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Change the offset once the block has drained every pending item.
  task automatic write_offset(input cfg_beat_t value);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    reloc_offset = value;
  endtask

  // Result sink: check each accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with no item pending: %p", out_ch.data);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.data.status);
          mismatch_count++;
        end
        if (out_ch.data.relocated_address !== want.relocated_address) begin
          $error("relocated_address: expected %h, got %h",
                 want.relocated_address, out_ch.data.relocated_address);
          mismatch_count++;
        end
        if (out_ch.data.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_ch.data.read_data);
          mismatch_count++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog: end the run after too many cycles without any beat moving.
  initial begin : watchdog
    int unsigned stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // Main sequence: reset, scripted rows, then random phases.
  initial begin : stimulus
    in_beat_t    item;
    out_beat_t   predicted;
    cfg_beat_t   offset_value;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 28;
    rx_idle_pct = 53;
    foreach (script[r]) begin
      if (script[r].kind == ROW_CONFIG) begin
        write_offset(script[r].cfg_value);
      end else begin
        send_item(script[r].item);
        predicted = relocate_step(script[r].item);
        awaited_results.push_back(script[r].typed ? script[r].result : predicted);
      end
    end

    // Idling: sender light and receiver heavy, then swapped, then none.
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          tx_idle_pct = 28;
          rx_idle_pct = 53;
        end
        1: begin
          tx_idle_pct = 53;
          rx_idle_pct = 28;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (phase)
        0: offset_value = 16'h0005;
        1: offset_value = 16'hFFFF;
        2: offset_value = 16'($urandom_range(0, 65535));
        3: offset_value = 16'hF000;
        4: offset_value = 16'h8000;
        default: offset_value = 16'h0000;
      endcase
      write_offset(offset_value);
      repeat (ITEMS_PER_PHASE) begin
        item = random_item();
        send_item(item);
        awaited_results.push_back(relocate_step(item));
      end
    end

    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
